>>> hdl/assert_macros.svh
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define OAHT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OAHT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OAHT_ASSERT(lbl, clk, rst, prop, msg)
`define OAHT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> hdl/oaht_pkg.sv
package oaht_pkg;

   localparam int HASH_SHIFT = 10;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_FETCH,
      S_PROBE
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic shift;
      logic fetch;
      logic advance;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic hash_last;
      logic finish;
   } sts_type;

endpackage

>>> hdl/oaht_if.sv
interface req_if #(
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 32
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            op;
   logic [KEY_BITS-1:0]   key;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, op, key, value, input ready);
   modport sink   (input valid, op, key, value, output ready);
endinterface

interface rsp_if #(
   parameter int SLOT_BITS  = 5,
   parameter int VALUE_BITS = 32
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [SLOT_BITS-1:0]  slot;
   logic [VALUE_BITS-1:0] record;

   modport source (output valid, status, slot, record, input ready);
   modport sink   (input valid, status, slot, record, output ready);
endinterface

>>> hdl/oaht_ctrl.sv
`include "assert_macros.svh"

module oaht_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  oaht_pkg::sts_type sts,
   output oaht_pkg::cmd_type cmd
);
   import oaht_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            cmd.shift = 1'b1;
            if (sts.hash_last) state_in = S_FETCH;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_PROBE;
         end
         S_PROBE: begin
            if (sts.finish) begin
               if (out_free) begin
                  cmd.commit = 1'b1;
                  state_in   = S_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   `OAHT_ASSERT(a_commit_drained, clock, reset, cmd.commit |-> out_free, "commit over held word")
   `OAHT_ASSERT(a_fetch_after_hash, clock, reset, (state_ff == S_FETCH) |-> ($past(state_ff) == S_HASH), "fetch without hash")
   `OAHT_ASSERT(a_rsp_from_commit, clock, reset, $rose(rsp_valid_ff) |-> $past(cmd.commit), "word without commit")

endmodule

>>> hdl/oaht_dp.sv
`include "assert_macros.svh"

module oaht_dp #(
   parameter int SLOTS      = 31,
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 32,
   localparam int SB        = $clog2(SLOTS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  oaht_pkg::cmd_type      cmd,
   output oaht_pkg::sts_type      sts,
   input  logic [1:0]             req_op,
   input  logic [KEY_BITS-1:0]    req_key,
   input  logic [VALUE_BITS-1:0]  req_value,
   output logic [1:0]             rsp_status,
   output logic [SB-1:0]          rsp_slot,
   output logic [VALUE_BITS-1:0]  rsp_record
);
   import oaht_pkg::*;

   localparam int WB = 1 + KEY_BITS + VALUE_BITS;
   localparam int HL = $clog2(SLOTS);
   localparam int SL = $clog2(SLOTS - 1);
   localparam int HS = KEY_BITS + HL;
   localparam int SS = KEY_BITS + SL;
   localparam int PB = 2 * KEY_BITS + 1;
   localparam logic [63:0] HM = ((64'd1 << HS) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
   localparam logic [63:0] SM = ((64'd1 << SS) + 64'(SLOTS - 1) - 64'd1) / 64'(SLOTS - 1);

   logic [WB-1:0]         mem [SLOTS];
   logic [WB-1:0]         rd_ff;
   logic [SB-1:0]         rd_addr, wr_addr;
   logic [WB-1:0]         wr_data;
   logic                  wr_en;

   op_type                op_ff;
   logic [KEY_BITS-1:0]   key_ff, x_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic                  cnt_ff;
   logic [PB-1:0]         ph_ff, ps_ff;
   logic [KEY_BITS-HL:0]  qh;
   logic [KEY_BITS-SL:0]  qs;
   logic [SB-1:0]         hr_ff, hr_in, sr_ff, sr_in;
   logic [SB-1:0]         cur_ff, nxt, step;
   logic [SB:0]           sum;
   logic [SB-1:0]         n_ff;
   logic [SB-1:0]         clr_ff;
   logic                  last;

   logic                  e_valid, match;
   logic [KEY_BITS-1:0]   e_key;
   logic [VALUE_BITS-1:0] e_val;
   logic                  finish, wr_need;
   status_type            status_in;
   logic [SB-1:0]         slot_in;
   logic [VALUE_BITS-1:0] rec_in;

   logic [1:0]            status_ff;
   logic [SB-1:0]         slot_ff;
   logic [VALUE_BITS-1:0] rec_ff;

   // hash: reciprocal multiply, then remainder; home mod SLOTS, step mod SLOTS-1
   assign qh    = ph_ff[PB-1:HS];
   assign qs    = ps_ff[PB-1:SS];
   assign hr_in = SB'(x_ff - KEY_BITS'(qh) * KEY_BITS'(SLOTS));
   assign sr_in = SB'(key_ff - KEY_BITS'(qs) * KEY_BITS'(SLOTS - 1));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(req_op);
         key_ff <= req_key;
         val_ff <= req_value;
         x_ff   <= (req_key >> HASH_SHIFT) ^ (req_key & KEY_BITS'(SLOTS - 1));
         cnt_ff <= 1'b1;
      end else if (cmd.shift) begin
         ph_ff  <= PB'(x_ff) * PB'(HM[KEY_BITS:0]);
         ps_ff  <= PB'(key_ff) * PB'(SM[KEY_BITS:0]);
         hr_ff  <= hr_in;
         sr_ff  <= sr_in;
         cnt_ff <= 1'b0;
      end
   end

   // probe walk
   assign step = sr_ff + SB'(1);
   assign sum  = {1'b0, cur_ff} + {1'b0, step};
   assign nxt  = (sum >= (SB+1)'(SLOTS)) ? SB'(sum - (SB+1)'(SLOTS)) : sum[SB-1:0];
   assign last = (n_ff == SB'(SLOTS - 1));

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         cur_ff <= hr_ff;
         n_ff   <= '0;
      end else if (cmd.advance) begin
         cur_ff <= nxt;
         n_ff   <= n_ff + SB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear && clr_ff != SB'(SLOTS - 1)) clr_ff <= clr_ff + SB'(1);
   end

   // table memory: {valid, key, value}
   always_comb begin
      if (cmd.fetch) rd_addr = hr_ff;
      else if (cmd.advance) rd_addr = nxt;
      else rd_addr = cur_ff;
   end

   assign wr_en   = cmd.clear || (cmd.commit && wr_need);
   assign wr_addr = cmd.clear ? clr_ff : cur_ff;
   assign wr_data = cmd.clear ? '0 : {(op_ff == OP_INSERT), key_ff, val_ff};

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   assign e_valid = rd_ff[WB-1];
   assign e_key   = rd_ff[WB-2 -: KEY_BITS];
   assign e_val   = rd_ff[VALUE_BITS-1:0];
   assign match   = e_valid && (e_key == key_ff);

   always_comb begin
      finish    = 1'b1;
      wr_need   = 1'b0;
      status_in = ST_NOT_FOUND;
      slot_in   = '0;
      rec_in    = '0;
      case (op_ff)
         OP_INSERT: begin
            finish = !e_valid || last;
            if (!e_valid) begin
               wr_need   = 1'b1;
               status_in = ST_OK;
               slot_in   = cur_ff;
            end else begin
               status_in = ST_FULL;
            end
         end
         OP_SEARCH: begin
            finish = !e_valid || match || last;
            if (match) begin
               status_in = ST_OK;
               slot_in   = cur_ff;
               rec_in    = e_val;
            end
         end
         OP_REMOVE: begin
            finish = !e_valid || match || last;
            if (match) begin
               wr_need   = 1'b1;
               status_in = ST_OK;
               slot_in   = cur_ff;
            end
         end
         default: finish = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         slot_ff   <= slot_in;
         rec_ff    <= rec_in;
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_slot      = slot_ff;
   assign rsp_record    = rec_ff;
   assign sts.clr_last  = (clr_ff == SB'(SLOTS - 1));
   assign sts.hash_last = (cnt_ff == 1'b0);
   assign sts.finish    = finish;

   `OAHT_ASSERT(a_cur_range, clock, reset, (cmd.fetch || cmd.advance) |=> (cur_ff <= SB'(SLOTS - 1)), "probe index out of range")
   `OAHT_ASSERT(a_step_range, clock, reset, (cmd.shift && sts.hash_last) |=> (sr_ff < SB'(SLOTS - 1)), "step out of range")
   `OAHT_ASSERT(a_insert_empty, clock, reset, (cmd.commit && op_ff == OP_INSERT && status_in == ST_OK) |-> !e_valid, "insert over used slot")

endmodule

>>> hdl/open_address_hash_table.sv
// Open-addressing hash table, double hashing, SLOTS entries of key and value.
// req_bus: one word per operation (op 0 insert, 1 search, 2 remove, key, value).
// rsp_bus: one word per operation (status 0 ok, 1 not found, 2 full; slot;
// record = value on a found search, else 0).
// Both channels move a word on a clock edge with valid and ready high.
// After reset a clearing pass writes every slot empty; req_bus.ready stays
// low until it ends.
// One operation at a time: home slot and probe step are formed by a
// reciprocal multiply, then a remainder, the first table read follows,
// then one probe per cycle, 1 to SLOTS probes through the single-read-port
// table memory; only a finished probe can wait, on the output register.
// The next word is accepted the cycle after the result is registered.
// The result sits in an output register; a stalled receiver holds it while
// the next operation is accepted and hashed, and a finished probe waits for
// that register to drain before it commits.
module open_address_hash_table #(
   parameter int SLOTS      = 31,
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   req_if.sink       req_bus,
   rsp_if.source     rsp_bus
);
   import oaht_pkg::*;

   localparam int SB = $clog2(SLOTS);

   cmd_type               cmd;
   sts_type               sts;
   logic [1:0]            status_w;
   logic [SB-1:0]         slot_w;
   logic [VALUE_BITS-1:0] record_w;

   oaht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   oaht_dp #(
      .SLOTS      (SLOTS),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_op     (req_bus.op),
      .req_key    (req_bus.key),
      .req_value  (req_bus.value),
      .rsp_status (status_w),
      .rsp_slot   (slot_w),
      .rsp_record (record_w)
   );

   assign rsp_bus.status = status_w;
   assign rsp_bus.slot   = slot_w;
   assign rsp_bus.record = record_w;

endmodule
